// ----- rtl/cld_pkg.sv -----
package cld_pkg;

    localparam logic [7:0]  CH_LF          = 8'h0A;
    localparam logic [7:0]  CH_CR          = 8'h0D;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd4096;

    // result queue: deep enough for two results of one byte plus what waits
    localparam int          FIFO_DEPTH     = 4;
    localparam int          FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CW        = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef enum logic {
        CMD_DATA  = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  line_byte;
        logic        last;
        logic [31:0] dropped_lines;
    } t_out_item;

    // results produced by one beat, handed to the result queue
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  res0;
        t_out_item  res1;
    } t_push;

endpackage

// ----- rtl/cld_frame.sv -----
module cld_frame (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_proc,
    input  cld_pkg::t_in_item  i_item,
    input  logic [15:0]        i_max_len,
    output cld_pkg::t_push     o_push
);
    import cld_pkg::*;

    logic        r_discarding, n_discarding;
    logic [15:0] r_partial, n_partial;
    logic        r_held_cr, n_held_cr;
    logic [31:0] r_dropped, n_dropped;
    logic [16:0] inc;

    function automatic t_out_item mk_res(t_kind kind, logic [7:0] b, logic lst,
                                         logic [31:0] dl);
        t_out_item r;
        r.kind          = kind;
        r.line_byte     = (kind == KIND_DATA) ? b : 8'd0;
        r.last          = lst;
        r.dropped_lines = dl;
        return r;
    endfunction

    assign inc = {1'b0, r_partial} + 17'd1;

    always_comb begin
        n_discarding = r_discarding;
        n_partial    = r_partial;
        n_held_cr    = r_held_cr;
        n_dropped    = r_dropped;
        o_push.cnt   = 2'd0;
        o_push.res0  = mk_res(KIND_DATA, 8'd0, 1'b0, r_dropped);
        o_push.res1  = mk_res(KIND_DATA, 8'd0, 1'b0, r_dropped);
        if (i_proc) begin
            if (i_item.command == CMD_CLEAR) begin
                n_discarding = 1'b0;
                n_partial    = 16'd0;
                n_held_cr    = 1'b0;
                if (r_partial != 16'd0) begin
                    o_push.cnt  = 2'd1;
                    o_push.res0 = mk_res(KIND_ABORT, 8'd0, 1'b1, r_dropped);
                end
            end else if (r_discarding) begin
                // skip to the end of the oversized line, count it there
                if (i_item.rx_byte == CH_LF) begin
                    n_discarding = 1'b0;
                    n_dropped    = r_dropped + 32'd1;
                end
            end else if (i_item.rx_byte == CH_LF) begin
                n_held_cr   = 1'b0;
                n_partial   = 16'd0;
                o_push.cnt  = 2'd1;
                o_push.res0 = mk_res(KIND_END, 8'd0, 1'b1, r_dropped);
            end else if (inc >= {1'b0, i_max_len}) begin
                n_partial    = 16'd0;
                n_held_cr    = 1'b0;
                n_discarding = 1'b1;
                o_push.cnt   = 2'd1;
                o_push.res0  = mk_res(KIND_ABORT, 8'd0, 1'b1, r_dropped);
            end else begin
                n_partial = inc[15:0];
                if (i_item.rx_byte == CH_CR) begin
                    // hold the new CR, release an earlier one
                    n_held_cr = 1'b1;
                    if (r_held_cr) begin
                        o_push.cnt  = 2'd1;
                        o_push.res0 = mk_res(KIND_DATA, CH_CR, 1'b1, r_dropped);
                    end
                end else begin
                    n_held_cr = 1'b0;
                    if (r_held_cr) begin
                        o_push.cnt  = 2'd2;
                        o_push.res0 = mk_res(KIND_DATA, CH_CR, 1'b0, r_dropped);
                        o_push.res1 = mk_res(KIND_DATA, i_item.rx_byte, 1'b1,
                                             r_dropped);
                    end else begin
                        o_push.cnt  = 2'd1;
                        o_push.res0 = mk_res(KIND_DATA, i_item.rx_byte, 1'b1,
                                             r_dropped);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discarding <= 1'b0;
            r_partial    <= 16'd0;
            r_held_cr    <= 1'b0;
            r_dropped    <= 32'd0;
        end else begin
            r_discarding <= n_discarding;
            r_partial    <= n_partial;
            r_held_cr    <= n_held_cr;
            r_dropped    <= n_dropped;
        end
    end

endmodule

// ----- rtl/cld_out_fifo.sv -----
module cld_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cld_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cld_pkg::t_out_item o_out_data
);
    import cld_pkg::*;

    t_out_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       r_wr, n_wr;
    logic [FIFO_AW-1:0]       r_rd, n_rd;
    logic [FIFO_CW-1:0]       r_count, n_count;
    logic                     pop;
    logic [FIFO_AW-1:0]       wr_next;

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd];
    assign pop         = o_out_valid & i_out_ready;
    // room for the worst case of two results from one beat
    assign o_room      = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign wr_next     = r_wr + FIFO_AW'(1);

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.cnt);
        n_rd    = pop ? r_rd + FIFO_AW'(1) : r_rd;
        n_count = r_count + FIFO_CW'(i_push.cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/capped_line_deframer.sv -----
// Capped line deframer: frames a received byte stream into LF-terminated lines.
// Input channel (i_in_*): one beat per received byte or clear command. Each
//   data byte is passed on at once as a line data result, except a CR, which
//   is held for one byte so that CR directly before LF is stripped. LF gives
//   a line end result. Reaching the configured length cap gives one line
//   aborted result; bytes are then dropped up to the next LF, where the
//   dropped line count advances. Clear aborts any partial line.
// Output channel (o_out_*): zero, one or two results per input beat; `last`
//   marks the final result of a beat, dropped_lines carries the running count.
// Config channel (i_cfg_*): writes the 16-bit line length cap; always ready,
//   to be written only while the block is idle.
// Flow: an accepted beat waits in the input register until the queue has
//   room, is then processed into the result queue, and its first result is
//   offered from the queue from then on. Throughput: one beat per cycle
//   while each beat gives at most one result; the four-entry result queue
//   sets the pace when beats give two results or the receiver stalls, and
//   input ready drops while a beat is held and fewer than two slots are free.
// Reset (synchronous, active low): framing state and the dropped line count go
//   to zero, the cap to 4096, the queue empties.
module capped_line_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cld_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cld_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import cld_pkg::*;

    logic        r_in_valid, n_in_valid;
    t_in_item    r_in;
    logic [15:0] r_max_len;
    logic        room;
    logic        proc;
    logic        in_acc;
    t_push       push;

    assign o_cfg_ready = 1'b1;

    // process the held beat only when the queue can take both possible results
    assign proc       = r_in_valid & room;
    // take a new beat whenever the input register is empty or drains now
    assign o_in_ready = ~r_in_valid | proc;
    assign in_acc     = i_in_valid & o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max_len  <= MAX_LEN_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    // payload register: load on every accepted beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    cld_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_proc    (proc),
        .i_item    (r_in),
        .i_max_len (r_max_len),
        .o_push    (push)
    );

    cld_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- test/cld_line_checker.sv -----
`timescale 1ns / 1ps

module cld_line_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  cld_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  cld_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output int                 o_mismatches,
    output int                 o_pending
);
    import cld_pkg::*;

    localparam logic [15:0] CAP_AT_RESET = 16'd4096;

    // own copy of the framer state
    logic [15:0] cap_len;
    bit          skipping;
    logic [16:0] part_len;
    bit          cr_waiting;
    logic [31:0] drop_total;

    t_out_item   line_results_due [$];
    int          mismatch_count;

    assign o_mismatches = mismatch_count;
    assign o_pending    = line_results_due.size();

    function automatic t_out_item make_result(t_kind k, logic [7:0] b);
        t_out_item r;
        r.kind          = k;
        r.line_byte     = (k == KIND_DATA) ? b : 8'h00;
        r.last          = 1'b0;
        r.dropped_lines = drop_total;
        return r;
    endfunction

    function automatic string fmt_result(t_out_item r);
        return $sformatf("kind %0d byte %02h last %0b dropped %0d",
                         r.kind, r.line_byte, r.last, r.dropped_lines);
    endfunction

    task automatic frame_beat(input t_in_item it);
        t_out_item due [$];
        if (it.command == CMD_CLEAR) begin
            if (part_len != 0)
                due.push_back(make_result(KIND_ABORT, 8'h00));
            skipping   = 1'b0;
            part_len   = '0;
            cr_waiting = 1'b0;
        end else if (skipping) begin
            if (it.rx_byte == CH_LF) begin
                skipping   = 1'b0;
                drop_total = drop_total + 32'd1;
            end
        end else if (it.rx_byte == CH_LF) begin
            cr_waiting = 1'b0;
            part_len   = '0;
            due.push_back(make_result(KIND_END, 8'h00));
        end else begin
            part_len = part_len + 17'd1;
            if (part_len >= {1'b0, cap_len}) begin
                // the held CR goes with the rest of the line
                part_len   = '0;
                cr_waiting = 1'b0;
                skipping   = 1'b1;
                due.push_back(make_result(KIND_ABORT, 8'h00));
            end else begin
                if (cr_waiting) begin
                    due.push_back(make_result(KIND_DATA, CH_CR));
                    cr_waiting = 1'b0;
                end
                if (it.rx_byte == CH_CR)
                    cr_waiting = 1'b1;
                else
                    due.push_back(make_result(KIND_DATA, it.rx_byte));
            end
        end
        if (due.size() > 0)
            due[due.size() - 1].last = 1'b1;
        foreach (due[i])
            line_results_due.push_back(due[i]);
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (!i_rst_n) begin
            cap_len    = CAP_AT_RESET;
            skipping   = 1'b0;
            part_len   = '0;
            cr_waiting = 1'b0;
            drop_total = '0;
            line_results_due.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                cap_len = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (line_results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: expected none, got %s", $time,
                             fmt_result(i_out_data));
                end else begin
                    exp_res = line_results_due.pop_front();
                    if (i_out_data.kind !== exp_res.kind
                            || i_out_data.line_byte !== exp_res.line_byte
                            || i_out_data.last !== exp_res.last
                            || i_out_data.dropped_lines !== exp_res.dropped_lines) begin
                        mismatch_count++;
                        $display("%0t: expected %s, got %s", $time,
                                 fmt_result(exp_res), fmt_result(i_out_data));
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                frame_beat(i_in_data);
        end
    end

endmodule

// ----- test/capped_line_deframer_test.sv -----
`timescale 1ns / 1ps

module capped_line_deframer_test;
    import cld_pkg::*;

    // cycles to let pass once nothing is expected, a margin for beats still in flight
    localparam int DRAIN_CYCLES = 12;
    // beats per random phase
    localparam int PHASE_BEATS  = 190;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    int          mismatches;
    int          pending;
    int          send_calm = 0;
    int          recv_calm = 0;

    logic [15:0] phase_caps [9];

    capped_line_deframer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    cld_line_checker checker_0 (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Draw the idle cycles before the next beat. Now and then start a calm
    // stretch of back-to-back beats so that full-rate phases are hit too.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) < 4) begin
            calm = $urandom_range(10, 50);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Byte for the body of a line: never an LF, often a CR.
    function automatic logic [7:0] pick_line_byte();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 15)
            return CH_CR;
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF)
            b = 8'h4C;
        return b;
    endfunction

    // Offer one beat on the input channel and hold it until accepted. Valid
    // is only lowered when a gap is drawn, so back-to-back beats keep it high.
    task automatic offer_beat(input t_cmd c, input logic [7:0] b);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: c, rx_byte: b};
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait until every predicted result has come out, then
    // allow for beats that give no result and may still be in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cap(input logic [15:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random run of beats: mostly whole lines sized around the cap,
    // some lines cut short by a clear, some raw noise.
    task automatic run_lines(input logic [15:0] cap, output int n);
        int span;
        int len;
        int sel;
        int cut;
        span = (cap < 2) ? 4 : ((cap > 60) ? 60 : int'(cap));
        sel  = $urandom_range(0, 99);
        n    = 0;
        if (sel < 80) begin
            len = $urandom_range(0, span + 2);
            repeat (len) offer_beat(CMD_DATA, pick_line_byte());
            if ($urandom_range(0, 1))
                offer_beat(CMD_DATA, CH_CR);
            offer_beat(CMD_DATA, CH_LF);
            n = len + 2;
        end else if (sel < 90) begin
            cut = $urandom_range(0, span + 1);
            repeat (cut) offer_beat(CMD_DATA, pick_line_byte());
            offer_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
            n = cut + 1;
        end else begin
            len = $urandom_range(1, 6);
            repeat (len) begin
                if ($urandom_range(0, 9) == 0)
                    offer_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
                else
                    offer_beat(CMD_DATA, 8'($urandom_range(0, 255)));
            end
            n = len;
        end
    endtask

    // Receiver: stall for a drawn number of cycles, then hold ready until
    // one result beat has been taken.
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int got;
        phase_caps = '{16'd2, 16'd1, 16'd0, 16'd5, 16'd9, 16'hFFFF, 16'd3,
                       16'd2, 16'd7};
        // randomise two of the phases
        phase_caps[4] = 16'($urandom_range(2, 64));
        phase_caps[8] = 16'($urandom_range(2, 20));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset cap: bare LF, CR stripping before LF,
        // CR passed on before another byte, CR followed by CR, extreme
        // bytes, and clears with and without a partial line.
        offer_beat(CMD_DATA, CH_LF);
        offer_beat(CMD_DATA, 8'h61);
        offer_beat(CMD_DATA, CH_LF);
        offer_beat(CMD_DATA, CH_CR);
        offer_beat(CMD_DATA, CH_LF);
        offer_beat(CMD_DATA, CH_CR);
        offer_beat(CMD_DATA, 8'h62);
        offer_beat(CMD_DATA, CH_CR);
        offer_beat(CMD_DATA, CH_CR);
        offer_beat(CMD_DATA, CH_LF);
        offer_beat(CMD_DATA, 8'h00);
        offer_beat(CMD_DATA, 8'hFF);
        offer_beat(CMD_CLEAR, 8'hFF);
        offer_beat(CMD_CLEAR, 8'h00);
        offer_beat(CMD_DATA, CH_CR);
        offer_beat(CMD_CLEAR, CH_LF);

        // Cap of three: abort, discard, counted drop; then a held CR
        // dropped with its line; then a cap of zero aborts on the first data byte.
        write_cap(16'd3);
        offer_beat(CMD_DATA, 8'h61);
        offer_beat(CMD_DATA, 8'h62);
        offer_beat(CMD_DATA, 8'h63);
        offer_beat(CMD_DATA, 8'h64);
        offer_beat(CMD_DATA, CH_LF);
        offer_beat(CMD_DATA, 8'h61);
        offer_beat(CMD_DATA, CH_CR);
        offer_beat(CMD_DATA, 8'h78);
        offer_beat(CMD_DATA, CH_LF);
        write_cap(16'd0);
        offer_beat(CMD_DATA, 8'h41);
        offer_beat(CMD_DATA, CH_LF);

        // Random phases, one cap each.
        foreach (phase_caps[p]) begin
            write_cap(phase_caps[p]);
            got = 0;
            while (got < PHASE_BEATS) begin
                int n;
                run_lines(phase_caps[p], n);
                got += n;
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
